// ===== hdl/oen_pkg.sv =====
// ----------------------------------------------------------------------------
// oen_pkg
// shared constants and types for the order event normalizer
// ----------------------------------------------------------------------------
package oen_pkg;
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_CHANGE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] EV_ADD    = 2'd0;
    localparam logic [1:0] EV_EXEC   = 2'd1;
    localparam logic [1:0] EV_REDUCE = 2'd2;
    localparam logic [1:0] EV_DELETE = 2'd3;

    localparam logic CFG_WIN_LOW  = 1'b0;
    localparam logic CFG_WIN_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [39:0] size;
        logic [39:0] price;
        logic        side;
        logic        suppressed;
        logic        pending;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic        side;
        logic [39:0] price;
        logic [39:0] qty;
    } t_event;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;
endpackage

// ===== hdl/order_event_normalizer.sv =====
// ----------------------------------------------------------------------------
// order_event_normalizer
// keeps a direct mapped table of live orders and emits normalized book events
// ----------------------------------------------------------------------------
// an item is taken with start while busy is low. the slot order_key mod
// TABLE_ENTRIES is read from a synchronous table memory, then
// the entry is updated and written back while zero to three book events
// are queued. events leave one per cycle on o_valid, with o_last on the
// final event of the item; the receiver cannot stall.
// busy stays high while the entry is read and written back and while the
// further events of the item leave, so the next item is not taken before
// its last event has been issued; the table memory has one read port and
// one write port.
// after reset the valid memory is swept clear, one entry a cycle, over all
// TABLE_ENTRIES entries with busy high; configuration writes on
// i_cfg_we/i_cfg_index/i_cfg_data are taken at any time.
// ----------------------------------------------------------------------------
module order_event_normalizer
    import oen_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [39:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_order_key,
    input  logic        i_order_side,
    input  logic [39:0] i_limit_price,
    input  logic [39:0] i_size_left,
    input  logic signed [39:0] i_size_traded,
    input  logic        i_traded_present,
    input  logic [39:0] i_touch_bid,
    input  logic [39:0] i_touch_ask,
    input  logic        i_bid_present,
    input  logic        i_ask_present,
    input  logic [62:0] i_event_time,
    output logic        o_valid,
    output logic [1:0]  o_book_event,
    output logic [63:0] o_out_key,
    output logic        o_out_side,
    output logic [39:0] o_out_price,
    output logic [39:0] o_out_quantity,
    output logic [47:0] o_sequence_res,
    output logic [62:0] o_out_time,
    output logic        o_last
);
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr;
    logic [39:0] r_win_low, r_win_high;

    // latched item
    logic [1:0]  r_op;
    logic [63:0] r_key;
    logic        r_side;
    logic [39:0] r_px, r_rem, r_traded;
    logic        r_mkt;
    logic [62:0] r_time;

    // memories
    logic        mem_valid [TABLE_ENTRIES];
    t_entry      mem_entry [TABLE_ENTRIES];
    logic        r_rd_valid;
    t_entry      r_rd_entry;
    logic        wr_en, wr_valid;
    t_entry      wr_entry;
    logic [IDX_W-1:0] wr_idx;

    // event queue
    t_event      r_ev [3];
    t_event      ev [3];
    logic [1:0]  r_cnt, r_pos, ev_n;
    logic [47:0] r_seq;

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != ST_IDLE);

    logic [IDX_W-1:0] slot;
    assign slot = r_key[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low  <= '0;
            r_win_high <= '1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WIN_LOW) r_win_low <= i_cfg_data;
            else r_win_high <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_key    <= i_order_key;
            r_side   <= i_order_side;
            r_px     <= i_limit_price;
            r_rem    <= i_size_left;
            r_traded <= (i_traded_present && !i_size_traded[39]) ?
                        i_size_traded : '0;
            r_mkt    <= i_order_side ? (i_bid_present && i_limit_price <= i_touch_bid)
                                     : (i_ask_present && i_limit_price >= i_touch_ask);
            r_time   <= i_event_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem_valid[wr_idx] <= wr_valid;
        r_rd_valid <= mem_valid[i_order_key[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_state == ST_READ) mem_entry[wr_idx] <= wr_entry;
        r_rd_entry <= mem_entry[i_order_key[IDX_W-1:0]];
    end

    // entry update and event generation
    logic inwin;
    assign inwin = (r_px >= r_win_low) && (r_px <= r_win_high);

    always_comb begin
        t_entry e;
        logic hit, keep, wr;
        logic [39:0] fill, sz;
        e = r_rd_entry;
        hit = r_rd_valid && (r_rd_entry.key == r_key);
        keep = r_rd_valid;
        wr = 1'b0;
        ev_n = 2'd0;
        for (int k = 0; k < 3; k++) ev[k] = '0;
        fill = (r_traded < e.size) ? r_traded : e.size;
        sz = e.size - fill;
        if (r_op == OP_CREATE) begin
            if (!r_rd_valid || hit) begin
                wr = 1'b1;
                keep = 1'b1;
                e.key = r_key;
                e.size = r_rem;
                e.price = r_px;
                e.side = r_side;
                e.suppressed = !inwin;
                e.pending = inwin && r_mkt;
                if (inwin && !r_mkt) begin
                    ev[0] = '{EV_ADD, r_side, r_px, r_rem};
                    ev_n = 2'd1;
                end
            end
        end else if ((r_op == OP_CHANGE || r_op == OP_DELETE) && hit) begin
            wr = 1'b1;
            if (e.suppressed) begin
                if (r_op == OP_DELETE) keep = 1'b0;
            end else if (e.pending) begin
                if (r_op == OP_DELETE) keep = 1'b0;
                else begin
                    e.size = r_rem;
                    e.price = r_px;
                    e.side = r_side;
                    if (r_rem != '0 && !r_mkt) begin
                        e.pending = 1'b0;
                        if (inwin) begin
                            ev[0] = '{EV_ADD, r_side, r_px, r_rem};
                            ev_n = 2'd1;
                        end else e.suppressed = 1'b1;
                    end
                end
            end else begin
                if (fill != '0) begin
                    ev[0] = '{EV_EXEC, e.side, e.price, fill};
                    ev_n = 2'd1;
                end
                e.size = sz;
                if (r_op == OP_DELETE) begin
                    keep = 1'b0;
                    if (sz != '0) begin
                        ev[ev_n] = '{EV_DELETE, e.side, e.price, sz};
                        ev_n = ev_n + 2'd1;
                    end
                end else if (r_px != e.price) begin
                    ev[ev_n] = '{EV_DELETE, e.side, e.price, sz};
                    ev_n = ev_n + 2'd1;
                    e.size = r_rem;
                    e.price = r_px;
                    e.side = r_side;
                    e.suppressed = !inwin;
                    e.pending = inwin && r_mkt;
                    if (inwin && !r_mkt) begin
                        ev[ev_n] = '{EV_ADD, r_side, r_px, r_rem};
                        ev_n = ev_n + 2'd1;
                    end
                end else if (r_rem < sz) begin
                    ev[ev_n] = '{EV_REDUCE, e.side, e.price, sz - r_rem};
                    ev_n = ev_n + 2'd1;
                    e.size = r_rem;
                end else if (r_rem > sz) begin
                    ev[ev_n] = '{EV_DELETE, e.side, e.price, sz};
                    ev[ev_n + 2'd1] = '{EV_ADD, r_side, r_px, r_rem};
                    ev_n = ev_n + 2'd2;
                    e.size = r_rem;
                    e.side = r_side;
                end
            end
        end
        wr_entry = e;
        if (r_state == ST_CLEAR) begin
            wr_en = 1'b1;
            wr_idx = r_clr;
            wr_valid = 1'b0;
        end else begin
            wr_en = (r_state == ST_READ) && wr;
            wr_idx = slot;
            wr_valid = keep;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == IDX_W'(TABLE_ENTRIES - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_READ;
            ST_READ:  n_state = (ev_n > 2'd1) ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (r_pos + 2'd1 >= r_cnt) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_seq   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            o_valid <= 1'b0;
            if (r_state == ST_READ) begin
                r_ev  <= ev;
                r_cnt <= ev_n;
                r_pos <= 2'd1;
                if (ev_n != 2'd0) begin
                    o_valid <= 1'b1;
                    r_seq   <= r_seq + 48'd1;
                end
            end else if (r_state == ST_EMIT) begin
                o_valid <= 1'b1;
                r_seq   <= r_seq + 48'd1;
                r_pos   <= r_pos + 2'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            o_book_event   <= ev[0].kind;
            o_out_side     <= ev[0].side;
            o_out_price    <= ev[0].price;
            o_out_quantity <= ev[0].qty;
            o_last         <= (ev_n == 2'd1);
            o_sequence_res <= r_seq + 48'd1;
        end else if (r_state == ST_EMIT) begin
            o_book_event   <= r_ev[r_pos].kind;
            o_out_side     <= r_ev[r_pos].side;
            o_out_price    <= r_ev[r_pos].price;
            o_out_quantity <= r_ev[r_pos].qty;
            o_last         <= (r_pos + 2'd1 == r_cnt);
            o_sequence_res <= r_seq + 48'd1;
        end
        o_out_key  <= r_key;
        o_out_time <= r_time;
    end
endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// order event normalizer: directed order events, then random ones driven in
// bursts over several price window settings; a scoreboard tracks its own
// copy of the order table and checks every book event field by field
// ----------------------------------------------------------------------------
module testbench;
    import oen_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic        side;
        logic [39:0] px;
        logic [39:0] rem;
        logic [39:0] traded;
        logic        tpres;
        logic [39:0] tb;
        logic [39:0] ta;
        logic        bp;
        logic        ap;
        logic [62:0] t;
    } t_order_item;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] key;
        logic        side;
        logic [39:0] px;
        logic [39:0] qty;
        logic [47:0] seq;
        logic [62:0] t;
        logic        last;
    } t_book_event;

    localparam logic [39:0] MAX40 = {40{1'b1}};
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam int          IDLE_LIMIT = 20000;

    class book_scoreboard;
        logic        valid_q[TABLE_ENTRIES];
        logic [63:0] key_q[TABLE_ENTRIES];
        logic [39:0] size_q[TABLE_ENTRIES];
        logic [39:0] price_q[TABLE_ENTRIES];
        logic        side_q[TABLE_ENTRIES];
        logic        supp_q[TABLE_ENTRIES];
        logic        pend_q[TABLE_ENTRIES];
        logic [47:0] seq_count;
        logic [39:0] win_lo;
        logic [39:0] win_hi;
        t_book_event book_events[$];
        int          mismatches;

        function new();
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            seq_count = '0;
            win_lo = '0;
            win_hi = MAX40;
            mismatches = 0;
        endfunction

        function bit in_win(logic [39:0] px);
            return px >= win_lo && px <= win_hi;
        endfunction

        function bit crosses(t_order_item it, logic side, logic [39:0] px);
            if (side == 1'b0) return it.ap && px >= it.ta;
            return it.bp && px <= it.tb;
        endfunction

        function void push_event(logic [1:0] kind, logic [63:0] key, logic side,
                                 logic [39:0] px, logic [39:0] qty, logic [62:0] t);
            t_book_event e;
            seq_count = seq_count + 48'd1;
            e.kind = kind; e.key = key; e.side = side; e.px = px; e.qty = qty;
            e.seq = seq_count; e.t = t; e.last = 1'b0;
            book_events = {book_events, e};
        endfunction

        function void enter(t_order_item it, int s);
            if (!in_win(it.px)) supp_q[s] = 1'b1;
            else if (crosses(it, it.side, it.px)) pend_q[s] = 1'b1;
            else push_event(EV_ADD, it.key, it.side, it.px, it.rem, it.t);
        endfunction

        function void note_order_event(t_order_item it);
            int s;
            bit hit;
            int n0;
            logic [39:0] traded, fill;
            s = int'(it.key[IDX_W-1:0]);
            hit = valid_q[s] && key_q[s] == it.key;
            n0 = book_events.size();
            if (it.op == OP_UNUSED) return;
            if (it.op == OP_CREATE) begin
                if (valid_q[s] && !hit) return;
                valid_q[s] = 1'b1; key_q[s] = it.key; size_q[s] = it.rem;
                price_q[s] = it.px; side_q[s] = it.side;
                supp_q[s] = 1'b0; pend_q[s] = 1'b0;
                enter(it, s);
            end else begin
                if (!hit) return;
                if (supp_q[s]) begin
                    if (it.op == OP_DELETE) valid_q[s] = 1'b0;
                    return;
                end
                if (pend_q[s]) begin
                    if (it.op == OP_DELETE) begin
                        valid_q[s] = 1'b0;
                        return;
                    end
                    size_q[s] = it.rem; price_q[s] = it.px; side_q[s] = it.side;
                    if (it.rem > 0 && !crosses(it, it.side, it.px)) begin
                        pend_q[s] = 1'b0;
                        if (in_win(it.px))
                            push_event(EV_ADD, it.key, it.side, it.px, it.rem, it.t);
                        else
                            supp_q[s] = 1'b1;
                    end
                end else begin
                    traded = (it.tpres && !it.traded[39]) ? it.traded : '0;
                    fill = traded < size_q[s] ? traded : size_q[s];
                    if (fill > 0) begin
                        push_event(EV_EXEC, it.key, side_q[s], price_q[s], fill, it.t);
                        size_q[s] = size_q[s] - fill;
                    end
                    if (it.op == OP_DELETE) begin
                        if (size_q[s] > 0)
                            push_event(EV_DELETE, it.key, side_q[s], price_q[s],
                                       size_q[s], it.t);
                        valid_q[s] = 1'b0;
                    end else if (it.px != price_q[s]) begin
                        push_event(EV_DELETE, it.key, side_q[s], price_q[s], size_q[s], it.t);
                        size_q[s] = it.rem; price_q[s] = it.px; side_q[s] = it.side;
                        enter(it, s);
                    end else if (it.rem < size_q[s]) begin
                        push_event(EV_REDUCE, it.key, side_q[s], price_q[s],
                                   size_q[s] - it.rem, it.t);
                        size_q[s] = it.rem;
                    end else if (it.rem > size_q[s]) begin
                        push_event(EV_DELETE, it.key, side_q[s], price_q[s], size_q[s], it.t);
                        push_event(EV_ADD, it.key, it.side, it.px, it.rem, it.t);
                        size_q[s] = it.rem;
                        side_q[s] = it.side;
                    end
                end
            end
            if (book_events.size() > n0) book_events[$].last = 1'b1;
        endfunction

        function void check_book_event(t_book_event got);
            t_book_event exp_ev;
            if (book_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected book event: kind %0d key %h seq %0d",
                             got.kind, got.key, got.seq);
                return;
            end
            exp_ev = book_events.pop_front();
            if (got.kind !== exp_ev.kind || got.key !== exp_ev.key ||
                got.side !== exp_ev.side || got.px !== exp_ev.px ||
                got.qty !== exp_ev.qty || got.seq !== exp_ev.seq ||
                got.t !== exp_ev.t || got.last !== exp_ev.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp kind %0d key %h side %0d px %0d qty %0d seq %0d ",
                              "t %0d last %0d / got kind %0d key %h side %0d px %0d qty %0d ",
                              "seq %0d t %0d last %0d"},
                             exp_ev.kind, exp_ev.key, exp_ev.side, exp_ev.px, exp_ev.qty,
                             exp_ev.seq, exp_ev.t, exp_ev.last, got.kind, got.key, got.side,
                             got.px, got.qty, got.seq, got.t, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [39:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [63:0] i_order_key = '0;
    logic        i_order_side = 1'b0;
    logic [39:0] i_limit_price = '0;
    logic [39:0] i_size_left = '0;
    logic [39:0] i_size_traded = '0;
    logic        i_traded_present = 1'b0;
    logic [39:0] i_touch_bid = '0;
    logic [39:0] i_touch_ask = '0;
    logic        i_bid_present = 1'b0;
    logic        i_ask_present = 1'b0;
    logic [62:0] i_event_time = '0;
    logic        o_valid;
    logic [1:0]  o_book_event;
    logic [63:0] o_out_key;
    logic        o_out_side;
    logic [39:0] o_out_price;
    logic [39:0] o_out_quantity;
    logic [47:0] o_sequence_res;
    logic [62:0] o_out_time;
    logic        o_last;

    book_scoreboard sb = new();
    logic [51:0]    key_tags[3];
    int             idle_cycles = 0;

    order_event_normalizer u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_book_event got;
        if (i_rst_n && o_valid) begin
            got.kind = o_book_event; got.key = o_out_key; got.side = o_out_side;
            got.px = o_out_price; got.qty = o_out_quantity; got.seq = o_sequence_res;
            got.t = o_out_time; got.last = o_last;
            sb.check_book_event(got);
        end
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [39:0] rand40();
        return 40'({$urandom, $urandom});
    endfunction

    task automatic send_item(t_order_item it);
        start <= 1'b1;
        i_operation <= it.op; i_order_key <= it.key; i_order_side <= it.side;
        i_limit_price <= it.px; i_size_left <= it.rem; i_size_traded <= it.traded;
        i_traded_present <= it.tpres; i_touch_bid <= it.tb; i_touch_ask <= it.ta;
        i_bid_present <= it.bp; i_ask_present <= it.ap; i_event_time <= it.t;
        do @(posedge i_clk); while (busy);
        sb.note_order_event(it);
    endtask

    task automatic do_item(logic [1:0] op, logic [63:0] key, logic side, logic [39:0] px,
                           logic [39:0] rem, logic [39:0] traded, logic tpres,
                           logic [39:0] tb, logic [39:0] ta, logic bp, logic ap);
        t_order_item it;
        it.op = op; it.key = key; it.side = side; it.px = px; it.rem = rem;
        it.traded = traded; it.tpres = tpres; it.tb = tb; it.ta = ta;
        it.bp = bp; it.ap = ap; it.t = 63'({$urandom, $urandom});
        send_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.book_events.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [39:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WIN_LOW) sb.win_lo = val;
        else sb.win_hi = val;
    endtask

    function automatic logic [63:0] pick_key();
        logic [11:0] slot;
        if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
        slot = ($urandom_range(0, 9) == 0) ? 12'hfff : 12'($urandom_range(0, 5));
        return {key_tags[$urandom_range(0, 2)], slot};
    endfunction

    function automatic t_order_item rand_item();
        t_order_item it;
        int r;
        it.t = 63'({$urandom, $urandom});
        if ($urandom_range(0, 9) == 0) begin
            it.op = 2'($urandom); it.key = {$urandom, $urandom}; it.side = 1'($urandom);
            it.px = rand40(); it.rem = rand40(); it.traded = rand40();
            it.tpres = 1'($urandom); it.tb = rand40(); it.ta = rand40();
            it.bp = 1'($urandom); it.ap = 1'($urandom);
            return it;
        end
        r = $urandom_range(0, 99);
        it.op = r < 35 ? OP_CREATE : r < 75 ? OP_CHANGE : r < 95 ? OP_DELETE : OP_UNUSED;
        it.key = pick_key();
        it.side = 1'($urandom);
        it.px = 40'd992 + 40'($urandom_range(0, 16));
        it.rem = ($urandom_range(0, 19) == 0) ? rand40() : 40'($urandom_range(0, 20));
        r = $urandom_range(0, 9);
        it.traded = r == 0 ? -40'($urandom_range(1, 9)) : r == 1 ? rand40()
                  : 40'($urandom_range(0, 12));
        it.tpres = $urandom_range(0, 4) != 0;
        it.tb = 40'd997 + 40'($urandom_range(0, 3));
        it.ta = 40'd1000 + 40'($urandom_range(0, 3));
        it.bp = $urandom_range(0, 5) != 0;
        it.ap = $urandom_range(0, 5) != 0;
        return it;
    endfunction

    task automatic random_phase(int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
            end
            send_item(rand_item());
            burst--;
        end
        drain();
    endtask

    initial begin
        logic [63:0] ka, kb;
        foreach (key_tags[i]) key_tags[i] = 52'({$urandom, $urandom});
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_WIN_LOW, '0);
        write_reg(CFG_WIN_HIGH, MAX40);
        ka = {key_tags[0], 12'd7};
        kb = {key_tags[1], 12'd7};

        // resting order life cycle
        do_item(OP_CREATE, ka, 1'b0, 40'd995, 40'd10, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd995, 40'd8, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd995, 40'd12, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd995, 40'd7, 40'd3, 1'b1, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd996, 40'd5, 40'd2, 1'b1, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b1, 40'd996, 40'd5, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd996, 40'd5, -40'sd4, 1'b1, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd996, 40'd5, 40'd2, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CREATE, kb, 1'b1, 40'd1003, 40'd4, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_DELETE, ka, 1'b0, 40'd996, 40'd0, 40'd2, 1'b1, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_DELETE, ka, 1'b0, 40'd996, 40'd0, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, kb, 1'b0, 40'd996, 40'd1, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        // marketable on arrival, then rests
        do_item(OP_CREATE, ka, 1'b0, 40'd1002, 40'd6, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd1002, 40'd5, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_CHANGE, ka, 1'b0, 40'd1002, 40'd5, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b0);
        do_item(OP_CREATE, ka, 1'b1, 40'd997, 40'd0, '0, 1'b0, 40'd998, 40'd1001,
                1'b0, 1'b1);
        do_item(OP_CREATE, ka, 1'b1, 40'd997, 40'd3, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        do_item(OP_DELETE, ka, 1'b1, 40'd997, 40'd3, '0, 1'b0, 40'd998, 40'd1001,
                1'b1, 1'b1);
        // extreme keys and fields
        do_item(OP_CREATE, '1, 1'b1, MAX40, MAX40, '0, 1'b0, MAX40, MAX40, 1'b1, 1'b1);
        do_item(OP_DELETE, '1, 1'b1, '0, '0, MAX40 >> 1, 1'b1, '0, '0, 1'b0, 1'b0);
        do_item(OP_CREATE, '0, 1'b0, '0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        do_item(OP_UNUSED, '0, 1'b0, '0, MAX40, '0, 1'b1, '0, '0, 1'b1, 1'b1);
        do_item(OP_DELETE, '0, 1'b0, '0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        do_item(OP_DELETE, kb, 1'b1, 40'd1003, '0, 40'd9, 1'b1, 40'd998, 40'd1001,
                1'b1, 1'b1);
        drain();
        random_phase(35);

        write_reg(CFG_WIN_LOW, 40'd996);
        write_reg(CFG_WIN_HIGH, 40'd1004);
        random_phase(40);

        write_reg(CFG_WIN_LOW, 40'd1001);
        write_reg(CFG_WIN_HIGH, 40'd999);
        random_phase(20);

        write_reg(CFG_WIN_LOW, 40'd1000);
        write_reg(CFG_WIN_HIGH, 40'd1000);
        random_phase(25);

        write_reg(CFG_WIN_LOW, MAX40);
        write_reg(CFG_WIN_HIGH, MAX40);
        random_phase(15);

        write_reg(CFG_WIN_LOW, '0);
        write_reg(CFG_WIN_HIGH, MAX40);
        random_phase(20);

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.book_events.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
